FILE: hdl/mlrq_pkg.sv
// Package for the multilevel ready-queue scheduler: sizes, codes and types.
// No dependencies.
`default_nettype none
package mlrq_pkg;
  localparam int unsigned MaxTasksDefault = 1024;
  localparam int unsigned LevelsDefault   = 5;
  localparam int unsigned TaskW  = 10;
  localparam int unsigned LevelW = 3;
  localparam int unsigned OpW    = 2;
  localparam int unsigned StatW  = 2;

  typedef enum logic [OpW-1:0] {
    OP_ENQ  = 2'd0,
    OP_PICK = 2'd1,
    OP_REM  = 2'd2,
    OP_POP  = 2'd3
  } op_e;

  typedef enum logic [StatW-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_LINK_RD,
    S_LINK_WAIT,
    S_WALK,
    S_OUT
  } state_e;

  typedef struct packed {
    logic [OpW-1:0]    opcode;
    logic [TaskW-1:0]  task_index;
    logic [LevelW-1:0] priority_req;
    logic              to_wait;
  } req_t;

  typedef struct packed {
    logic [TaskW-1:0] result_task;
    logic [StatW-1:0] status;
  } rsp_t;
endpackage
`default_nettype wire

FILE: hdl/mlrq_if.sv
// Valid/ready channel interfaces for request and response items.
// Depends on mlrq_pkg.
`default_nettype none
interface mlrq_req_if;
  import mlrq_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mlrq_rsp_if;
  import mlrq_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hdl/mlrq_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module mlrq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]              rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

FILE: hdl/multilevel_ready_queue_scheduler_top.sv
// Multilevel ready-queue scheduler: per-level linked FIFOs plus a wait FIFO.
// One item at a time: the next is taken only after the response, which is
// held until rsp.ready. Enqueue and rejected requests answer after decode;
// pick scans the levels, two passes when none is found; pop reads the wait
// head's link if any; remove walks the level to a hit, unlinked, or the end.
// Reset (rst_ni low, async) empties every FIFO; the link RAM is not cleared.
`default_nettype none
module multilevel_ready_queue_scheduler_top #(
  parameter int unsigned MaxTasks = mlrq_pkg::MaxTasksDefault,
  parameter int unsigned Levels   = mlrq_pkg::LevelsDefault
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  mlrq_req_if.sink   req,
  mlrq_rsp_if.source rsp
);
  import mlrq_pkg::*;

  localparam int unsigned AddrW = (MaxTasks > 1) ? $clog2(MaxTasks) : 1;
  localparam int unsigned CntW  = $clog2(MaxTasks + 1);
  localparam int unsigned LvlIW = (Levels > 1) ? $clog2(Levels) : 1;
  localparam int unsigned PtrW  = (AddrW > TaskW) ? AddrW : TaskW;

  state_e state_q, state_d;
  req_t   req_q;

  logic [PtrW-1:0] lhead_q [Levels];
  logic [PtrW-1:0] ltail_q [Levels];
  logic [CntW-1:0] lcnt_q  [Levels];
  logic [CntW-1:0] rcnt_q  [Levels];
  logic [PtrW-1:0] whead_q, wtail_q;
  logic [CntW-1:0] wcnt_q;

  logic [LvlIW-1:0] lvl_q;
  logic             pass_q;
  logic             tgt_wait_q;   // link read serves the wait FIFO
  logic             is_rem_q;
  logic [PtrW-1:0]  cur_q, prev_q;
  logic [CntW-1:0]  k_q;
  logic [TaskW-1:0] res_q;
  logic [StatW-1:0] st_q;

  // Link RAM
  logic             we;
  logic [AddrW-1:0] waddr, raddr;
  logic [PtrW-1:0]  wdata, rdata;
  mlrq_ram #(.Width(PtrW), .Depth(MaxTasks)) u_link (
    .clk_i(clk_i), .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  logic [LvlIW-1:0] req_lvl;
  logic             lvl_ok, task_ok;
  assign req_lvl = LvlIW'(req_q.priority_req);
  assign lvl_ok  = 32'(req_q.priority_req) < Levels;
  assign task_ok = 32'(req_q.task_index) < MaxTasks;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:      if (req.valid) state_d = S_DECODE;
      S_DECODE: begin
        unique case (op_e'(req_q.opcode))
          OP_PICK: state_d = S_SCAN;
          OP_POP:  state_d = (wcnt_q == '0) ? S_OUT : S_LINK_RD;
          OP_REM:  state_d = (!lvl_ok || !task_ok || lcnt_q[req_lvl] == '0)
                             ? S_OUT : S_WALK;
          default: state_d = S_OUT;
        endcase
      end
      S_SCAN: begin
        if (rcnt_q[lvl_q] < lcnt_q[lvl_q]) state_d = S_LINK_RD;
        else if (32'(lvl_q) == Levels - 1 && pass_q) state_d = S_OUT;
      end
      S_LINK_RD:   state_d = S_LINK_WAIT;
      S_LINK_WAIT: state_d = (is_rem_q && TaskW'(cur_q) != req_q.task_index)
                             ? S_WALK : S_OUT;
      S_WALK: begin
        // Read the link of a hit too, so it can be spliced out
        if (TaskW'(cur_q) != req_q.task_index && k_q + 1'b1 >= lcnt_q[lvl_q])
          state_d = S_OUT;
        else state_d = S_LINK_RD;
      end
      S_OUT:       if (rsp.ready) state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    req.ready = (state_q == S_IDLE);
    rsp.valid = (state_q == S_OUT);
    rsp.data.result_task = res_q;
    rsp.data.status      = st_q;
    raddr = AddrW'(cur_q);
  end

  // Link write for appends and remove unlinks
  always_comb begin
    we = 1'b0; waddr = '0; wdata = '0;
    if (state_q == S_DECODE && op_e'(req_q.opcode) == OP_ENQ && task_ok) begin
      if (req_q.to_wait) begin
        we = (wcnt_q != '0) && 32'(wcnt_q) < MaxTasks;
        waddr = AddrW'(wtail_q);
      end else if (lvl_ok) begin
        we = (lcnt_q[req_lvl] != '0) && 32'(lcnt_q[req_lvl]) < MaxTasks;
        waddr = AddrW'(ltail_q[req_lvl]);
      end
      wdata = PtrW'(req_q.task_index);
    end else if (state_q == S_LINK_WAIT && is_rem_q && k_q != '0 &&
                 TaskW'(cur_q) == req_q.task_index) begin
      we = 1'b1; waddr = AddrW'(prev_q);
      wdata = (k_q + 1'b1 == lcnt_q[lvl_q]) ? '0 : rdata;
    end
  end

  // Control and queue state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      req_q <= '0;
      for (int i = 0; i < Levels; i++) begin
        lhead_q[i] <= '0; ltail_q[i] <= '0; lcnt_q[i] <= '0; rcnt_q[i] <= '0;
      end
      whead_q <= '0; wtail_q <= '0; wcnt_q <= '0;
      lvl_q <= '0; pass_q <= 1'b0; tgt_wait_q <= 1'b0; is_rem_q <= 1'b0;
      cur_q <= '0; prev_q <= '0; k_q <= '0; res_q <= '0; st_q <= ST_DONE;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        S_IDLE: if (req.valid) req_q <= req.data;
        S_DECODE: begin
          res_q <= '0; st_q <= ST_DONE; lvl_q <= '0; pass_q <= 1'b0;
          is_rem_q <= 1'b0; k_q <= '0; prev_q <= '0;
          unique case (op_e'(req_q.opcode))
            OP_ENQ: begin
              if (req_q.to_wait) begin
                if (!task_ok || 32'(wcnt_q) >= MaxTasks) st_q <= ST_EMPTY;
                else begin
                  if (wcnt_q == '0) whead_q <= PtrW'(req_q.task_index);
                  wtail_q <= PtrW'(req_q.task_index);
                  wcnt_q  <= wcnt_q + 1'b1;
                end
              end else if (!lvl_ok) st_q <= ST_RANGE;
              else if (!task_ok || 32'(lcnt_q[req_lvl]) >= MaxTasks) st_q <= ST_EMPTY;
              else begin
                if (lcnt_q[req_lvl] == '0) lhead_q[req_lvl] <= PtrW'(req_q.task_index);
                ltail_q[req_lvl] <= PtrW'(req_q.task_index);
                lcnt_q[req_lvl]  <= lcnt_q[req_lvl] + 1'b1;
              end
            end
            OP_PICK: ;
            OP_POP: begin
              if (wcnt_q == '0) st_q <= ST_EMPTY;
              else begin
                res_q <= TaskW'(whead_q); cur_q <= whead_q; tgt_wait_q <= 1'b1;
              end
            end
            default: begin
              if (!lvl_ok) st_q <= ST_RANGE;
              else if (!task_ok || lcnt_q[req_lvl] == '0) st_q <= ST_EMPTY;
              else begin
                lvl_q <= req_lvl; cur_q <= lhead_q[req_lvl]; is_rem_q <= 1'b1;
              end
            end
          endcase
        end
        S_SCAN: begin
          if (rcnt_q[lvl_q] < lcnt_q[lvl_q]) begin
            res_q <= TaskW'(lhead_q[lvl_q]); cur_q <= lhead_q[lvl_q];
            tgt_wait_q <= 1'b0;
            rcnt_q[lvl_q] <= rcnt_q[lvl_q] + 1'b1;
          end else begin
            rcnt_q[lvl_q] <= '0;
            if (32'(lvl_q) == Levels - 1) begin
              lvl_q <= '0; pass_q <= 1'b1;
              if (pass_q) st_q <= ST_EMPTY;
            end else lvl_q <= lvl_q + 1'b1;
          end
        end
        S_LINK_RD: ;
        S_LINK_WAIT: begin
          if (is_rem_q) begin
            // Hit handled here uses the fresh link of the current node
            if (TaskW'(cur_q) == req_q.task_index) begin
              if (k_q == '0 && k_q + 1'b1 != lcnt_q[lvl_q]) lhead_q[lvl_q] <= rdata;
              if (k_q != '0 && k_q + 1'b1 == lcnt_q[lvl_q]) ltail_q[lvl_q] <= prev_q;
              lcnt_q[lvl_q] <= lcnt_q[lvl_q] - 1'b1;
              res_q <= req_q.task_index;
            end else begin
              prev_q <= cur_q; cur_q <= rdata; k_q <= k_q + 1'b1;
            end
          end else if (tgt_wait_q) begin
            if (wcnt_q > 1) whead_q <= rdata;
            wcnt_q <= wcnt_q - 1'b1;
          end else begin
            if (lcnt_q[lvl_q] > 1) lhead_q[lvl_q] <= rdata;
            lcnt_q[lvl_q] <= lcnt_q[lvl_q] - 1'b1;
          end
        end
        S_WALK: begin
          // Flag a miss once the last node does not match
          if (TaskW'(cur_q) != req_q.task_index && k_q + 1'b1 >= lcnt_q[lvl_q])
            st_q <= ST_EMPTY;
        end
        S_OUT: ;
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req.ready && rsp.valid)) else $error("ready and response valid together");
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
    else $error("response dropped while stalled");
  a_wcnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(wcnt_q) <= MaxTasks) else $error("wait count overflow");
  a_run_le: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_OUT |-> (st_q == ST_DONE || st_q == ST_RANGE || st_q == ST_EMPTY))
    else $error("bad status code");
`endif
endmodule
`default_nettype wire
